[design/pos_pkg.sv]
// Shared types and constants for the pulse odometer stall monitor.
`default_nettype none
package pos_pkg;

  localparam int COUNT_BITS_DEF = 32;
  localparam int TIME_BITS_DEF  = 32;
  localparam int REG_W          = 32;
  localparam int CMD_W          = 32;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic [REG_W-1:0] DEBOUNCE_RST = 32'd2000;
  localparam logic [REG_W-1:0] STALL_RST    = 32'd180000;
  localparam logic [REG_W-1:0] REPORT_RST   = 32'd7200000;
  localparam logic [REG_W-1:0] TARGET_RST   = 32'd142858;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_PULSE = 2'd1,
    ACT_CMD   = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    EV_STALL  = 2'd0,
    EV_REPORT = 2'd1,
    EV_TARGET = 2'd2,
    EV_RESET  = 2'd3
  } event_t;

  typedef enum logic [1:0] {
    CFG_DEBOUNCE = 2'd0,
    CFG_STALL    = 2'd1,
    CFG_REPORT   = 2'd2,
    CFG_TARGET   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic             we;
    logic [1:0]       index;
    logic [REG_W-1:0] data;
  } cfg_wr_t;

  // One accepted item's results: one or two events sharing count and running.
  typedef struct packed {
    logic        two;
    event_t      ev0;
    event_t      ev1;
    logic [31:0] count;
    logic        running;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage
`default_nettype wire

[design/pos_in_if.sv]
// Input channel: ticks, sensor pulses and remote commands.
`default_nettype none
interface pos_in_if import pos_pkg::*;;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic signed [CMD_W-1:0] command_value;

  modport source (output valid, output action, output command_value, input ready);
  modport sink   (input valid, input action, input command_value, output ready);
endinterface
`default_nettype wire

[design/pos_out_if.sv]
// Result channel: stall, report, target and count-reset events.
`default_nettype none
interface pos_out_if import pos_pkg::*;;
  logic        valid;
  logic        ready;
  logic [1:0]  event_res;
  logic [31:0] pulse_count;
  logic        running;
  logic        last;

  modport source (output valid, output event_res, output pulse_count, output running,
                  output last, input ready);
  modport sink   (input valid, input event_res, input pulse_count, input running,
                  input last, output ready);
endinterface
`default_nettype wire

[design/pos_front.sv]
// Front end: configuration, odometer state and event classification per item.
`default_nettype none
module pos_front import pos_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  parameter int TIME_BITS  = TIME_BITS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  pos_in_if.sink         in_ch,
  input  wire cfg_wr_t   cfg,
  input  wire q_status_t q_stat,
  output logic           q_push,
  output q_entry_t       q_entry
);

  localparam int TCW = (TIME_BITS > REG_W) ? TIME_BITS : REG_W;
  localparam int CCW = (COUNT_BITS > REG_W) ? COUNT_BITS : REG_W;

  logic [REG_W-1:0]      debounce_r, debounce_nxt;
  logic [REG_W-1:0]      stall_r, stall_nxt;
  logic [REG_W-1:0]      report_r, report_nxt;
  logic [REG_W-1:0]      target_r, target_nxt;
  logic [TIME_BITS-1:0]  now_r, now_nxt;
  logic [TIME_BITS-1:0]  last_pulse_r, last_pulse_nxt;
  logic [TIME_BITS-1:0]  report_base_r, report_base_nxt;
  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic                  stalled_r, stalled_nxt;
  logic                  target_hit_r, target_hit_nxt;
  logic [CMD_W-1:0]      prior_cmd_r, prior_cmd_nxt;

  logic                  accept;
  logic [TIME_BITS-1:0]  now_inc;
  logic [TIME_BITS-1:0]  tick_gap;
  logic [TIME_BITS-1:0]  rep_gap;
  logic [TIME_BITS-1:0]  pulse_gap;
  logic                  stall_hit;
  logic                  rep_hit;
  logic                  tgt_hit;

  assign in_ch.ready = !q_stat.full;
  assign accept      = in_ch.valid && !q_stat.full;

  assign now_inc   = now_r + TIME_BITS'(1);
  assign tick_gap  = now_inc - last_pulse_r;
  assign rep_gap   = now_inc - report_base_r;
  assign pulse_gap = now_r - last_pulse_r;

  assign stall_hit = !stalled_r && (TCW'(tick_gap) >= TCW'(stall_r));
  // A stall on this tick suppresses the report but not the target event.
  assign rep_hit   = !(stalled_r || stall_hit) && (TCW'(rep_gap) >= TCW'(report_r));
  assign tgt_hit   = !rep_hit && !target_hit_r && (CCW'(count_r) >= CCW'(target_r));

  always_comb begin
    debounce_nxt    = debounce_r;
    stall_nxt       = stall_r;
    report_nxt      = report_r;
    target_nxt      = target_r;
    now_nxt         = now_r;
    last_pulse_nxt  = last_pulse_r;
    report_base_nxt = report_base_r;
    count_nxt       = count_r;
    stalled_nxt     = stalled_r;
    target_hit_nxt  = target_hit_r;
    prior_cmd_nxt   = prior_cmd_r;
    q_push          = 1'b0;
    q_entry.two     = 1'b0;
    q_entry.ev0     = EV_STALL;
    q_entry.ev1     = EV_STALL;

    if (cfg.we) begin
      case (cfg.index)
        CFG_DEBOUNCE: debounce_nxt = cfg.data;
        CFG_STALL:    stall_nxt    = cfg.data;
        CFG_REPORT:   report_nxt   = cfg.data;
        CFG_TARGET:   target_nxt   = cfg.data;
        default: ;
      endcase
    end

    if (accept) begin
      case (in_ch.action)
        ACT_TICK: begin
          now_nxt = now_inc;
          if (stall_hit) stalled_nxt = 1'b1;
          if (rep_hit) report_base_nxt = report_base_r + TIME_BITS'(report_r);
          if (tgt_hit) target_hit_nxt = 1'b1;
          q_push = stall_hit || rep_hit || tgt_hit;
          if (stall_hit) begin
            q_entry.ev0 = EV_STALL;
            q_entry.two = rep_hit || tgt_hit;
            q_entry.ev1 = rep_hit ? EV_REPORT : EV_TARGET;
          end else begin
            q_entry.ev0 = rep_hit ? EV_REPORT : EV_TARGET;
          end
        end
        ACT_PULSE: begin
          if (TCW'(pulse_gap) >= TCW'(debounce_r)) begin
            count_nxt      = count_r + COUNT_BITS'(1);
            last_pulse_nxt = now_r;
            stalled_nxt    = 1'b0;
          end
        end
        ACT_CMD: begin
          prior_cmd_nxt = in_ch.command_value;
          if (in_ch.command_value != prior_cmd_r) begin
            count_nxt   = '0;
            q_push      = 1'b1;
            q_entry.ev0 = EV_RESET;
          end
        end
        default: ;
      endcase
    end

    q_entry.count   = 32'(count_nxt);
    q_entry.running = !stalled_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r    <= DEBOUNCE_RST;
      stall_r       <= STALL_RST;
      report_r      <= REPORT_RST;
      target_r      <= TARGET_RST;
      now_r         <= '0;
      last_pulse_r  <= '0;
      report_base_r <= '0;
      count_r       <= '0;
      stalled_r     <= 1'b0;
      target_hit_r  <= 1'b0;
      prior_cmd_r   <= '0;
    end else begin
      debounce_r    <= debounce_nxt;
      stall_r       <= stall_nxt;
      report_r      <= report_nxt;
      target_r      <= target_nxt;
      now_r         <= now_nxt;
      last_pulse_r  <= last_pulse_nxt;
      report_base_r <= report_base_nxt;
      count_r       <= count_nxt;
      stalled_r     <= stalled_nxt;
      target_hit_r  <= target_hit_nxt;
      prior_cmd_r   <= prior_cmd_nxt;
    end
  end

endmodule
`default_nettype wire

[design/pos_queue.sv]
// Short queue of per-item event records between front and back.
`default_nettype none
module pos_queue import pos_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire q_entry_t push_entry,
  input  wire logic     pop,
  output q_entry_t      head,
  output q_status_t     stat
);

  localparam int PTRW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

  q_entry_t            mem_r [QUEUE_DEPTH];
  logic [PTRW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PTRW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CNTW-1:0]     fill_r, fill_nxt;
  logic                do_push;
  logic                do_pop;

  assign stat.full  = (fill_r == CNTW'(QUEUE_DEPTH));
  assign stat.empty = (fill_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTRW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTRW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTRW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTRW'(1);
    end
    if (do_push && !do_pop) fill_nxt = fill_r + CNTW'(1);
    else if (do_pop && !do_push) fill_nxt = fill_r - CNTW'(1);
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

endmodule
`default_nettype wire

[design/pos_back.sv]
// Back end: splits queued records into single events and drives the output register.
`default_nettype none
module pos_back import pos_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire q_entry_t  head,
  input  wire q_status_t q_stat,
  output logic           pop,
  pos_out_if.source      out_ch
);

  logic        valid_r, valid_nxt;
  logic        phase_r, phase_nxt;
  logic [1:0]  event_r;
  logic [31:0] count_r;
  logic        running_r;
  logic        last_r;
  logic        load;
  logic        sel_last;
  event_t      sel_ev;

  assign load     = !q_stat.empty && (!valid_r || out_ch.ready);
  assign sel_last = !head.two || phase_r;
  assign sel_ev   = phase_r ? head.ev1 : head.ev0;
  assign pop      = load && sel_last;

  always_comb begin
    valid_nxt = valid_r;
    phase_nxt = phase_r;
    if (load) begin
      valid_nxt = 1'b1;
      phase_nxt = !sel_last;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      phase_r <= phase_nxt;
    end
  end

  // Hold the payload while the sink stalls.
  always_ff @(posedge clk) begin
    if (load) begin
      event_r   <= sel_ev;
      count_r   <= head.count;
      running_r <= head.running;
      last_r    <= sel_last;
    end
  end

  assign out_ch.valid       = valid_r;
  assign out_ch.event_res   = event_r;
  assign out_ch.pulse_count = count_r;
  assign out_ch.running     = running_r;
  assign out_ch.last        = last_r;

endmodule
`default_nettype wire

[design/pulse_odometer_stall_monitor.sv]
// Pulse odometer with stall, report and target events over a millisecond time base.
// Results pass through the queue and then the output register; a stalled sink holds them.
// Throughput: one input item per cycle while the queue is not full; the output register
// moves one result per cycle while the sink is ready, so an item with two results holds
// the output for both of them (two-entry queue between).
// Reset (synchronous, active low): registers to defaults, state zero, queue and output empty.
`default_nettype none
module pulse_odometer_stall_monitor import pos_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  parameter int TIME_BITS  = TIME_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  pos_in_if.sink                in_ch,
  pos_out_if.source             out_ch,
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [REG_W-1:0] cfg_wdata
);

  cfg_wr_t   cfg;
  q_status_t q_stat;
  q_entry_t  q_entry;
  q_entry_t  q_head;
  logic      q_push;
  logic      q_pop;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_wdata;

  pos_front #(
    .COUNT_BITS(COUNT_BITS),
    .TIME_BITS (TIME_BITS)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg    (cfg),
    .q_stat (q_stat),
    .q_push (q_push),
    .q_entry(q_entry)
  );

  pos_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_entry(q_entry),
    .pop       (q_pop),
    .head      (q_head),
    .stat      (q_stat)
  );

  pos_back u_back (
    .clk   (clk),
    .rst_n (rst_n),
    .head  (q_head),
    .q_stat(q_stat),
    .pop   (q_pop),
    .out_ch(out_ch)
  );

`ifndef SYNTH
  // A pulse never produces a result.
  a_pulse_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.action == ACT_PULSE) |-> !q_push)
    else $error("pulse transfer produced an event");

  // A two-event record always starts with the stall event.
  a_two_starts_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && q_entry.two) |-> (q_entry.ev0 == EV_STALL))
    else $error("two-event record without leading stall");

  // The second event of an item follows its first without a gap.
  a_second_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.last) |=> out_ch.valid)
    else $error("second event of an item missing");

  // Never pop an empty queue.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("pop from empty queue");
`endif

endmodule
`default_nettype wire

[tb/tb_pulse_odometer_stall_monitor.sv]
// Testbench for the pulse odometer stall monitor: random and directed items checked by a scoreboard.
module tb_pulse_odometer_stall_monitor;
  import pos_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;

  typedef struct {
    event_t      ev;
    logic [31:0] count;
    logic        running;
    logic        is_last;
  } odo_event_t;

  class odometer_tracker;
    logic [31:0] debounce_r, stall_r, report_r, target_r;
    logic [31:0] now_ms, last_pulse_ms, report_base_ms, pulses, prior_cmd;
    bit          stalled, target_hit;
    odo_event_t  pending_events[$];
    int          errors;

    function new();
      debounce_r     = DEBOUNCE_RST;
      stall_r        = STALL_RST;
      report_r       = REPORT_RST;
      target_r       = TARGET_RST;
      now_ms         = '0;
      last_pulse_ms  = '0;
      report_base_ms = '0;
      pulses         = '0;
      prior_cmd      = '0;
      stalled        = 1'b0;
      target_hit     = 1'b0;
      errors         = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [31:0] v);
      case (idx)
        CFG_DEBOUNCE: debounce_r = v;
        CFG_STALL:    stall_r = v;
        CFG_REPORT:   report_r = v;
        CFG_TARGET:   target_r = v;
        default: ;
      endcase
    endfunction

    function void push_event(event_t ev);
      odo_event_t e;
      e.ev      = ev;
      e.count   = pulses;
      e.running = !stalled;
      e.is_last = 1'b0;
      pending_events.push_back(e);
    endfunction

    // Advance the odometer by one accepted item and queue the events it raises.
    function void accept_item(logic [1:0] act, logic [31:0] cmd);
      int n;
      n = pending_events.size();
      case (act)
        ACT_TICK: begin
          now_ms = now_ms + 1;
          if (!stalled && (now_ms - last_pulse_ms) >= stall_r) begin
            stalled = 1'b1;
            push_event(EV_STALL);
          end
          if (!stalled && (now_ms - report_base_ms) >= report_r) begin
            report_base_ms = report_base_ms + report_r;
            push_event(EV_REPORT);
          end else if (!target_hit && pulses >= target_r) begin
            target_hit = 1'b1;
            push_event(EV_TARGET);
          end
        end
        ACT_PULSE: begin
          if ((now_ms - last_pulse_ms) >= debounce_r) begin
            pulses        = pulses + 1;
            last_pulse_ms = now_ms;
            stalled       = 1'b0;
          end
        end
        ACT_CMD: begin
          if (cmd != prior_cmd) begin
            pulses = '0;
            push_event(EV_RESET);
          end
          prior_cmd = cmd;
        end
        default: ;
      endcase
      if (pending_events.size() > n)
        pending_events[pending_events.size() - 1].is_last = 1'b1;
    endfunction

    function void compare_event(logic [1:0] ev, logic [31:0] cnt, logic run, logic lst);
      odo_event_t e;
      if (pending_events.size() == 0) begin
        $error("unexpected event_res %0d with pulse_count %0d", ev, cnt);
        errors++;
        return;
      end
      e = pending_events.pop_front();
      if (ev !== e.ev) begin
        $error("event_res: expected %0d, got %0d", e.ev, ev);
        errors++;
      end
      if (cnt !== e.count) begin
        $error("pulse_count: expected %0d, got %0d", e.count, cnt);
        errors++;
      end
      if (run !== e.running) begin
        $error("running: expected %0b, got %0b", e.running, run);
        errors++;
      end
      if (lst !== e.is_last) begin
        $error("last: expected %0b, got %0b", e.is_last, lst);
        errors++;
      end
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [1:0]       cfg_index;
  logic [REG_W-1:0] cfg_wdata;
  bit               steady;

  pos_in_if  in_ch();
  pos_out_if out_ch();

  odometer_tracker odo = new();

  pulse_odometer_stall_monitor dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: check every transfer, stall at random unless in a steady stretch.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        odo.compare_event(out_ch.event_res, out_ch.pulse_count, out_ch.running, out_ch.last);
      out_ch.ready <= steady || ($urandom_range(99) >= 34);
    end
  end

  task automatic send_item(input logic [1:0] act, input logic [31:0] val);
    while (!steady && $urandom_range(99) < 34) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.action        <= act;
    in_ch.command_value <= val;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    odo.accept_item(act, val);
  endtask

  // Hold the input idle until every expected event is out, then let the pipe empty.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (odo.pending_events.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(input cfg_reg_t idx, input logic [31:0] v);
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    odo.set_reg(idx, v);
  endtask

  task automatic configure(input logic [31:0] debounce, input logic [31:0] stall,
                           input logic [31:0] report, input logic [31:0] target);
    cfg_we <= 1'b1;
    put_reg(CFG_DEBOUNCE, debounce);
    put_reg(CFG_STALL, stall);
    put_reg(CFG_REPORT, report);
    put_reg(CFG_TARGET, target);
    cfg_we <= 1'b0;
  endtask

  task automatic random_items(input int n, input int tick_pct, input int pulse_pct);
    int          done;
    int          r;
    logic [31:0] val;
    done = 0;
    while (done < n) begin
      r = $urandom_range(99);
      if (r < tick_pct) begin
        send_item(ACT_TICK, $urandom);
        done++;
      end else if (r < tick_pct + pulse_pct) begin
        send_item(ACT_PULSE, $urandom);
        done++;
      end else if (r < 97) begin
        // repeat the prior value often so the no-change path is exercised
        case ($urandom_range(9))
          0, 1, 2, 3: val = odo.prior_cmd;
          4:          val = 32'h8000_0000;
          5:          val = 32'h7fff_ffff;
          6:          val = '1;
          default:    val = $urandom;
        endcase
        send_item(ACT_CMD, val);
        done++;
      end else begin
        send_item(ACT_UNUSED, $urandom);
      end
    end
  endtask

  initial begin
    int ph;
    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.action        <= ACT_TICK;
    in_ch.command_value <= '0;
    cfg_we              <= 1'b0;
    cfg_index           <= CFG_DEBOUNCE;
    cfg_wdata           <= '0;
    steady = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Defaults: command handling, debounced pulse at time zero, ignored action.
    send_item(ACT_CMD, '0);
    send_item(ACT_CMD, 32'h7fff_ffff);
    send_item(ACT_CMD, 32'h7fff_ffff);
    send_item(ACT_CMD, 32'h8000_0000);
    send_item(ACT_CMD, '1);
    send_item(ACT_PULSE, '0);
    send_item(ACT_UNUSED, '1);
    send_item(ACT_TICK, '0);
    send_item(ACT_TICK, '0);
    settle();

    // Zero debounce, stall interval and target: stall and target on the same tick.
    configure('0, '0, '1, '0);
    send_item(ACT_TICK, '0);
    send_item(ACT_PULSE, '0);
    send_item(ACT_PULSE, '0);
    send_item(ACT_TICK, '0);
    send_item(ACT_TICK, '0);
    send_item(ACT_CMD, '0);
    send_item(ACT_UNUSED, '0);
    settle();

    // Report on every running tick, no stall.
    configure('0, '1, 32'd1, '1);
    send_item(ACT_PULSE, '0);
    send_item(ACT_TICK, '0);
    send_item(ACT_TICK, '0);
    send_item(ACT_CMD, 32'd5);
    send_item(ACT_TICK, '0);
    settle();

    steady = 1'b1;
    configure(32'd2, 32'd40, 32'd15, 32'd60);
    random_items(300, 65, 25);
    settle();
    steady = 1'b0;

    configure('0, '0, 32'd1, '0);
    random_items(200, 60, 25);
    settle();

    configure('1, '1, '1, '1);
    random_items(80, 60, 25);
    settle();

    for (ph = 0; ph < 4; ph++) begin
      configure($urandom_range(6), $urandom_range(80, 5), $urandom_range(50, 1),
                $urandom_range(400));
      random_items(190, $urandom_range(85, 50), 20);
      settle();
    end

    repeat (10) @(posedge clk);
    if (odo.errors == 0 && odo.pending_events.size() == 0)
      $display("** pulse_odometer_stall_monitor: PASSED **");
    else
      $display("** pulse_odometer_stall_monitor: FAILED **");
    $finish;
  end

  initial begin
    #2000000;
    $display("** pulse_odometer_stall_monitor: FAILED **");
    $finish;
  end

endmodule
